@@ hdl/skts_pkg.sv @@
// ----------------------------------------------------------------------------
// skts_pkg
// shared types, codes and the microcode program of the sorted key table
// ----------------------------------------------------------------------------
`default_nettype none

package skts_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int ACTION_W   = 2;
  localparam int KEY_W      = 16;
  localparam int VALUE_IN_W = 16;
  localparam int STATUS_W   = 2;
  localparam int UPC_W      = 4;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SORT   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNSORTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // microcode addresses
  localparam logic [UPC_W-1:0] U_CLEAR       = 4'd0;
  localparam logic [UPC_W-1:0] U_ADD         = 4'd1;
  localparam logic [UPC_W-1:0] U_SORT_INIT   = 4'd2;
  localparam logic [UPC_W-1:0] U_RD_I        = 4'd3;
  localparam logic [UPC_W-1:0] U_LATCH_I     = 4'd4;
  localparam logic [UPC_W-1:0] U_RD_JM1      = 4'd5;
  localparam logic [UPC_W-1:0] U_SHIFT       = 4'd6;
  localparam logic [UPC_W-1:0] U_PLACE       = 4'd7;
  localparam logic [UPC_W-1:0] U_SRCH_INIT   = 4'd8;
  localparam logic [UPC_W-1:0] U_PROBE       = 4'd9;
  localparam logic [UPC_W-1:0] U_COMPARE     = 4'd10;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ADD,
    OP_SORT_INIT,
    OP_RD_I,
    OP_LATCH_I,
    OP_RD_JM1,
    OP_SHIFT,
    OP_PLACE,
    OP_SRCH_INIT,
    OP_PROBE,
    OP_COMPARE
  } dp_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_CNT_GT1,
    C_J_ZERO,
    C_KEY_GT,
    C_I_NEXT_LT,
    C_SORTED,
    C_LO_LT_HI,
    C_KEY_NE
  } cond_t;

  typedef struct packed {
    dp_op_t           op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             last;
  } ctrl_t;

  function automatic ctrl_t uword(dp_op_t op, cond_t cond, logic [UPC_W-1:0] target,
                                  logic last);
    ctrl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // control store: jump on condition, else finish on last, else fall through
  function automatic ctrl_t ucode_rom(logic [UPC_W-1:0] addr);
    ctrl_t w;
    case (addr)
      U_CLEAR:     w = uword(OP_CLEAR,     C_NEVER,     U_CLEAR,   1'b1);
      U_ADD:       w = uword(OP_ADD,       C_NEVER,     U_ADD,     1'b1);
      U_SORT_INIT: w = uword(OP_SORT_INIT, C_CNT_GT1,   U_RD_I,    1'b1);
      U_RD_I:      w = uword(OP_RD_I,      C_NEVER,     U_RD_I,    1'b0);
      U_LATCH_I:   w = uword(OP_LATCH_I,   C_NEVER,     U_LATCH_I, 1'b0);
      U_RD_JM1:    w = uword(OP_RD_JM1,    C_J_ZERO,    U_PLACE,   1'b0);
      U_SHIFT:     w = uword(OP_SHIFT,     C_KEY_GT,    U_RD_JM1,  1'b0);
      U_PLACE:     w = uword(OP_PLACE,     C_I_NEXT_LT, U_RD_I,    1'b1);
      U_SRCH_INIT: w = uword(OP_SRCH_INIT, C_SORTED,    U_PROBE,   1'b1);
      U_PROBE:     w = uword(OP_PROBE,     C_LO_LT_HI,  U_COMPARE, 1'b1);
      U_COMPARE:   w = uword(OP_COMPARE,   C_KEY_NE,    U_PROBE,   1'b1);
      default:     w = uword(OP_NOP,       C_NEVER,     U_CLEAR,   1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry_addr(logic [ACTION_W-1:0] action);
    logic [UPC_W-1:0] a;
    unique case (action)
      ACT_CLEAR:  a = U_CLEAR;
      ACT_ADD:    a = U_ADD;
      ACT_SORT:   a = U_SORT_INIT;
      ACT_LOOKUP: a = U_SRCH_INIT;
      default:    a = U_CLEAR;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ hdl/skts_ram.sv @@
// ----------------------------------------------------------------------------
// skts_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module skts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/sorted_key_table_search_top.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_search_top
// Key to value table with clear, add, stable insertion sort and binary search
// lookup. One transaction goes in, one result transaction comes out. The
// table lives in one ram with a single read port and registered read data,
// and a small microcode program steps a plain datapath over it. A lookup
// probes at most floor(log2 n) + 1 entries for n entries; a sort reads each
// entry after the first and moves each larger neighbor before it up one place.
// Input is held off (in_stall) from acceptance until the result is in the
// output register; the output register itself may still be waiting on
// out_stall while the next transaction is accepted. A lookup before the
// first sort after a clear or add answers unsorted. No clearing pass is run:
// only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_search_top
  import skts_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input transaction channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ACTION_W-1:0]   action,
  input  wire logic [KEY_W-1:0]      key,
  input  wire logic [VALUE_IN_W-1:0] value,
  // result transaction channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [STATUS_W-1:0]   status,
  output logic      [VALUE_IN_W-1:0] found_value
);

  localparam int IW = $clog2(TABLE_DEPTH);       // entry index
  localparam int CW = $clog2(TABLE_DEPTH + 1);   // fill count, 0..depth
  localparam int EW = KEY_W + VALUE_WIDTH;       // ram word {key, value}

  // sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_RUN  = 3'b010,
    SQ_HOLD = 3'b100
  } sq_state_t;

  sq_state_t state, state_next;
  logic [UPC_W-1:0] upc, upc_next;
  ctrl_t            ctrl;
  logic             jump;

  // latched transaction
  logic [KEY_W-1:0]       key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [EW-1:0]          val_ext;

  // table bookkeeping
  logic [CW-1:0] count, count_next;
  logic          sorted, sorted_next;

  // sort registers: outer index, insert position, entry being inserted
  logic [CW-1:0]          i, i_next;
  logic [CW-1:0]          j, j_next;
  logic [KEY_W-1:0]       k_r, k_r_next;
  logic [VALUE_WIDTH-1:0] v_r, v_r_next;

  // search registers: hi_x is one past the upper bound
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi_x, hi_x_next;
  logic [IW-1:0] mid_r, mid_r_next;

  // pending result
  logic [STATUS_W-1:0]   st, st_next;
  logic [VALUE_IN_W-1:0] fv, fv_next;
  logic                  out_valid_next;
  logic [STATUS_W-1:0]   status_next;
  logic [VALUE_IN_W-1:0] found_value_next;

  // ram port
  logic                   we;
  logic [IW-1:0]          waddr;
  logic [EW-1:0]          wdata;
  logic [IW-1:0]          raddr;
  logic [EW-1:0]          rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [EW-1:0]          rd_val_ext;

  // derived datapath values
  logic [CW-1:0] j_m1;
  logic [CW:0]   i_inc;
  logic [CW:0]   mid_sum;
  logic [CW:0]   mid_half;
  logic [IW-1:0] mid_c;
  logic          out_free;

  skts_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state != SQ_IDLE);
  assign out_free = !out_valid || !out_stall;

  // value handle trimmed to the stored width, and widened back on the way out
  assign val_ext    = EW'(value);
  assign rd_key     = rdata[EW-1:VALUE_WIDTH];
  assign rd_val     = rdata[VALUE_WIDTH-1:0];
  assign rd_val_ext = {{VALUE_IN_W{1'b0}}, rd_val};

  assign j_m1     = j - CW'(1);
  assign i_inc    = {1'b0, i} + (CW+1)'(1);
  // midpoint floor((lo + hi) / 2) with hi = hi_x - 1, used only when lo < hi_x
  assign mid_sum  = {1'b0, lo} + {1'b0, hi_x} - (CW+1)'(1);
  assign mid_half = mid_sum >> 1;
  assign mid_c    = mid_half[IW-1:0];

  assign ctrl = ucode_rom(upc);

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      C_NEVER:     jump = 1'b0;
      C_CNT_GT1:   jump = (count > CW'(1));
      C_J_ZERO:    jump = (j == '0);
      C_KEY_GT:    jump = (rd_key > k_r);
      C_I_NEXT_LT: jump = (i_inc < {1'b0, count});
      C_SORTED:    jump = sorted;
      C_LO_LT_HI:  jump = (lo < hi_x);
      C_KEY_NE:    jump = (rd_key != key_r);
      default:     jump = 1'b0;
    endcase
  end

  // sequencer and datapath
  always_comb begin
    state_next       = state;
    upc_next         = upc;
    count_next       = count;
    sorted_next      = sorted;
    i_next           = i;
    j_next           = j;
    k_r_next         = k_r;
    v_r_next         = v_r;
    lo_next          = lo;
    hi_x_next        = hi_x;
    mid_r_next       = mid_r;
    st_next          = st;
    fv_next          = fv;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    found_value_next = found_value;
    we               = 1'b0;
    waddr            = count[IW-1:0];
    wdata            = {key_r, val_r};
    raddr            = i[IW-1:0];

    unique case (state)
      SQ_IDLE: begin
        if (in_valid) begin
          upc_next   = entry_addr(action);
          fv_next    = '0;
          state_next = SQ_RUN;
        end
      end

      SQ_RUN: begin
        unique case (ctrl.op)
          OP_NOP: begin
          end
          OP_CLEAR: begin
            count_next  = '0;
            sorted_next = 1'b0;
            st_next     = ST_OK;
          end
          OP_ADD: begin
            if (count == CW'(TABLE_DEPTH)) begin
              st_next = ST_FULL;
            end else begin
              we          = 1'b1;
              waddr       = count[IW-1:0];
              wdata       = {key_r, val_r};
              count_next  = count + CW'(1);
              sorted_next = 1'b0;
              st_next     = ST_OK;
            end
          end
          OP_SORT_INIT: begin
            i_next      = CW'(1);
            sorted_next = 1'b1;
            st_next     = ST_OK;
          end
          OP_RD_I: begin
            raddr = i[IW-1:0];
          end
          OP_LATCH_I: begin
            k_r_next = rd_key;
            v_r_next = rd_val;
            j_next   = i;
          end
          OP_RD_JM1: begin
            raddr = j_m1[IW-1:0];
          end
          OP_SHIFT: begin
            // larger neighbor moves up one place
            if (rd_key > k_r) begin
              we     = 1'b1;
              waddr  = j[IW-1:0];
              wdata  = rdata;
              j_next = j_m1;
            end
          end
          OP_PLACE: begin
            we     = 1'b1;
            waddr  = j[IW-1:0];
            wdata  = {k_r, v_r};
            i_next = i_inc[CW-1:0];
          end
          OP_SRCH_INIT: begin
            lo_next   = '0;
            hi_x_next = count;
            st_next   = ST_UNSORTED;
          end
          OP_PROBE: begin
            raddr      = mid_c;
            mid_r_next = mid_c;
            st_next    = ST_NOT_FOUND;
          end
          OP_COMPARE: begin
            if (key_r == rd_key) begin
              st_next = ST_OK;
              fv_next = rd_val_ext[VALUE_IN_W-1:0];
            end else if (key_r > rd_key) begin
              lo_next = CW'(mid_r) + CW'(1);
            end else begin
              hi_x_next = CW'(mid_r);
            end
          end
          default: begin
          end
        endcase

        if (jump) begin
          upc_next = ctrl.target;
        end else if (ctrl.last) begin
          if (out_free) begin
            out_valid_next   = 1'b1;
            status_next      = st_next;
            found_value_next = fv_next;
            state_next       = SQ_IDLE;
          end else begin
            state_next = SQ_HOLD;
          end
        end else begin
          upc_next = upc + UPC_W'(1);
        end
      end

      SQ_HOLD: begin
        // result done, output register still occupied
        if (out_free) begin
          out_valid_next   = 1'b1;
          status_next      = st;
          found_value_next = fv;
          state_next       = SQ_IDLE;
        end
      end

      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_IDLE;
      upc       <= U_CLEAR;
      count     <= '0;
      sorted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      upc       <= upc_next;
      count     <= count_next;
      sorted    <= sorted_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SQ_IDLE && in_valid) begin
      key_r <= key;
      val_r <= val_ext[VALUE_WIDTH-1:0];
    end
    i           <= i_next;
    j           <= j_next;
    k_r         <= k_r_next;
    v_r         <= v_r_next;
    lo          <= lo_next;
    hi_x        <= hi_x_next;
    mid_r       <= mid_r_next;
    st          <= st_next;
    fv          <= fv_next;
    status      <= status_next;
    found_value <= found_value_next;
  end

endmodule

`default_nettype wire

@@ hdl/skts_assert.sv @@
// ----------------------------------------------------------------------------
// skts_assert
// port level checks of the sorted key table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module skts_assert
  import skts_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [ACTION_W-1:0]   action,
  input wire logic [KEY_W-1:0]      key,
  input wire logic [VALUE_IN_W-1:0] value,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [STATUS_W-1:0]   status,
  input wire logic [VALUE_IN_W-1:0] found_value
);

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(action) && $stable(key) && $stable(value))
    else $error("input changed while stalled");

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_value))
    else $error("result changed while stalled");

  // one transaction at a time: input is held off right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  // a value is only returned with a found status
  a_value_only_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> found_value == '0)
    else $error("nonzero found_value without found status");

  // clear answers ok in a single step when the output is free
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_CLEAR && !out_valid
      |=> ##1 out_valid && status == ST_OK)
    else $error("clear result missing or wrong");

endmodule

bind sorted_key_table_search_top skts_assert u_skts_assert (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .action      (action),
  .key         (key),
  .value       (value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .found_value (found_value)
);

`default_nettype wire

@@ test/key_table_checker.sv @@
// ----------------------------------------------------------------------------
// key_table_checker
// watches both channels of the sorted key table, predicts the answer of every
// accepted transaction and compares each result against the oldest prediction
// ----------------------------------------------------------------------------

module key_table_checker
  import skts_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [KEY_W-1:0]      key,
  input  logic [VALUE_IN_W-1:0] value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [STATUS_W-1:0]   status,
  input  logic [VALUE_IN_W-1:0] found_value,
  output int                    pending,
  output int                    mismatches
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [VALUE_IN_W-1:0] VALUE_MASK =
    (VALUE_WIDTH >= VALUE_IN_W) ? '1 : VALUE_IN_W'((32'd1 << VALUE_WIDTH) - 1);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [VALUE_IN_W-1:0] found;
  } table_answer_t;

  // shadow of the table contents
  logic [KEY_W-1:0]      tbl_key [TABLE_DEPTH];
  logic [VALUE_IN_W-1:0] tbl_val [TABLE_DEPTH];
  int                    fill;
  logic                  ordered;

  table_answer_t answers_due[$];

  initial begin
    pending    = 0;
    mismatches = 0;
    fill       = 0;
    ordered    = 1'b0;
  end

  // stable insertion sort by key
  function automatic void sort_table();
    int                    i;
    int                    j;
    logic [KEY_W-1:0]      k;
    logic [VALUE_IN_W-1:0] v;
    for (i = 1; i < fill && i < TABLE_DEPTH; i++) begin
      k = tbl_key[i];
      v = tbl_val[i];
      j = i;
      while (j > 0 && tbl_key[j-1] > k) begin
        tbl_key[j] = tbl_key[j-1];
        tbl_val[j] = tbl_val[j-1];
        j--;
      end
      tbl_key[j] = k;
      tbl_val[j] = v;
    end
  endfunction

  // binary search, midpoint floor((lo+hi)/2)
  function automatic table_answer_t search_table(logic [KEY_W-1:0] k);
    table_answer_t a;
    int            lo;
    int            hi;
    int            mid;
    logic          done;
    a.status = ST_NOT_FOUND;
    a.found  = '0;
    lo   = 0;
    hi   = fill - 1;
    done = 1'b0;
    while (!done && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (mid < 0 || mid >= TABLE_DEPTH) begin
        done = 1'b1;
      end else if (k > tbl_key[mid]) begin
        lo = mid + 1;
      end else if (k < tbl_key[mid]) begin
        hi = mid - 1;
      end else begin
        a.status = ST_OK;
        a.found  = tbl_val[mid];
        done     = 1'b1;
      end
    end
    return a;
  endfunction

  // applies one transaction to the shadow table and returns its answer
  function automatic table_answer_t table_answer(logic [ACTION_W-1:0] act,
                                                 logic [KEY_W-1:0] k,
                                                 logic [VALUE_IN_W-1:0] v);
    table_answer_t a;
    a.status = ST_OK;
    a.found  = '0;
    case (act)
      ACT_CLEAR: begin
        fill    = 0;
        ordered = 1'b0;
      end
      ACT_ADD: begin
        if (fill >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          tbl_key[fill] = k;
          tbl_val[fill] = v & VALUE_MASK;
          fill++;
          ordered = 1'b0;
        end
      end
      ACT_SORT: begin
        sort_table();
        ordered = 1'b1;
      end
      default: begin
        if (!ordered) a.status = ST_UNSORTED;
        else          a = search_table(k);
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin : watch
    table_answer_t want;
    table_answer_t got;
    if (rst) begin
      fill    = 0;
      ordered = 1'b0;
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.status = status;
        got.found  = found_value;
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: status %0d value %h",
                     $realtime, got.status, got.found);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status || got.found !== want.found) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: status exp %0d got %0d, value exp %h got %h",
                       $realtime, want.status, got.status, want.found, got.found);
          end
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(table_answer(action, key, value));
    end
    pending <= answers_due.size();
  end

endmodule

@@ test/sorted_key_table_search_top_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_search_top_tb
// drives clear/add/sort/lookup transactions into the key table with bursty
// input and a patterned output stall; a checker beside the block predicts
// and compares every result, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------

module sorted_key_table_search_top_tb
  import skts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int ITEM_TARGET = 1550;
  localparam int HOLD_CYCLES = 300;
  // the quiet limit leaves room for the worst case sort of a full reversed table
  localparam int QUIET_LIMIT = 30000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action = ACT_CLEAR;
  logic [KEY_W-1:0]      key = '0;
  logic [VALUE_IN_W-1:0] value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [VALUE_IN_W-1:0] found_value;

  int pending;
  int mismatches;
  int quiet_cycles = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int n_sent = 0;
  int burst_left = 1;
  bit no_gaps = 1'b0;

  // keys the table holds since the last clear, used to aim lookups at hits
  logic [KEY_W-1:0] keys_in[$];

  always #5 clk = ~clk;

  sorted_key_table_search_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_value (found_value)
  );

  key_table_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (DEF_VALUE_WIDTH)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_value (found_value),
    .pending     (pending),
    .mismatches  (mismatches)
  );

  // ---------------------------------------------------------------------------
  // watchdog: cycles without any accepted transaction on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("sorted_key_table_search_top_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: spans of random length, each with its own stall pattern;
  // a long hold-off is taken whenever the stimulus asks for one
  // ---------------------------------------------------------------------------
  always begin : rx_pattern
    int span;
    int mode;
    int per;
    int k;
    span = $urandom_range(5, 80);
    mode = $urandom_range(0, 3);
    per  = $urandom_range(2, 7);
    for (k = 0; k < span; k++) begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        // keep the result stalled long enough for the input to back up
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 0);
        2:       out_stall <= ($urandom_range(0, 4) == 0);
        default: out_stall <= ((k % per) < (per / 2));
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // mostly keys in the table, some neighbors of them, some anywhere
  function automatic logic [KEY_W-1:0] lookup_key();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 9);
    if (keys_in.size() == 0 || r >= 8) return rnd16();
    k = keys_in[$urandom_range(0, keys_in.size() - 1)];
    if (r == 7) return k + 1'b1;
    if (r == 6) return k - 1'b1;
    return k;
  endfunction

  // offer one transaction and hold it until accepted; then maybe end the burst
  task automatic send(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k,
                      logic [VALUE_IN_W-1:0] v);
    in_valid <= 1'b1;
    action   <= act;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
    n_sent++;
    case (act)
      ACT_CLEAR: keys_in.delete();
      ACT_ADD:   if (keys_in.size() < TABLE_DEPTH) keys_in.push_back(k);
      default:   ;
    endcase
    burst_left--;
    if (burst_left <= 0 && !no_gaps) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 30)
                                        : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                               : $urandom_range(10, 60);
    end
  endtask

  // stop offering until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic hold_burst();
    holds_asked <= holds_asked + 1;
    no_gaps = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 2) == 0) send(ACT_ADD, rnd16(), rnd16());
      else                          send(ACT_LOOKUP, lookup_key(), rnd16());
    end
    no_gaps = 1'b0;
  endtask

  // one well-formed pass: clear, fill, sort, look up, plus some disorder
  task automatic run_sequence();
    int               n_add;
    int               n_look;
    int               shape;
    int               r;
    int               i;
    int               step;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] k;
    send(ACT_CLEAR, rnd16(), rnd16());
    r = $urandom_range(0, 19);
    if (r == 0)      n_add = $urandom_range(60, 70);   // can run into full
    else if (r <= 2) n_add = $urandom_range(20, 63);
    else             n_add = $urandom_range(0, 12);
    shape = $urandom_range(0, 3);
    // reversed large tables make slow sorts, keep them rare
    if (n_add > 20 && shape == 3 && $urandom_range(0, 3) != 0) shape = 0;
    base = rnd16();
    step = $urandom_range(1, 300);
    for (i = 0; i < n_add; i++) begin
      case (shape)
        0:       k = rnd16();
        1:       k = base + KEY_W'($urandom_range(0, 7));   // many duplicates
        2:       k = base + KEY_W'(i * step);
        default: k = base - KEY_W'(i * step);
      endcase
      send(ACT_ADD, k, rnd16());
    end
    // lookup refused on an unsorted table
    if ($urandom_range(0, 4) == 0) send(ACT_LOOKUP, lookup_key(), rnd16());
    send(ACT_SORT, rnd16(), rnd16());
    n_look = $urandom_range(1, 15);
    repeat (n_look) send(ACT_LOOKUP, lookup_key(), rnd16());
    // add after sort: unsorts the table, or is dropped when the table is full
    if ($urandom_range(0, 3) == 0) begin
      send(ACT_ADD, rnd16(), rnd16());
      send(ACT_LOOKUP, lookup_key(), rnd16());
    end
    // noise: any action with any fields
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        send(ACT_CLEAR + ACTION_W'($urandom_range(0, 3)), rnd16(), rnd16());
    end
  endtask

  // ---------------------------------------------------------------------------
  // main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int seq_no;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unsorted after reset, empty table, extremes, duplicates
    send(ACT_LOOKUP, 16'h0000, 16'hFFFF);
    send(ACT_SORT,   16'hFFFF, 16'h0000);
    send(ACT_LOOKUP, 16'hFFFF, 16'h0000);   // empty sorted table: not found
    send(ACT_ADD,    16'h0000, 16'hFFFF);
    send(ACT_ADD,    16'hFFFF, 16'h0000);
    send(ACT_ADD,    16'h8000, 16'hAAAA);
    send(ACT_ADD,    16'h8000, 16'h5555);   // duplicate key
    send(ACT_ADD,    16'h0001, 16'h1234);
    send(ACT_LOOKUP, 16'h8000, 16'h0000);   // refused, not sorted yet
    send(ACT_SORT,   16'h0000, 16'h0000);
    send(ACT_LOOKUP, 16'h0000, 16'h0000);
    send(ACT_LOOKUP, 16'hFFFF, 16'h0000);
    send(ACT_LOOKUP, 16'h8000, 16'h0000);
    send(ACT_LOOKUP, 16'h7FFF, 16'h0000);
    send(ACT_CLEAR,  16'hFFFF, 16'hFFFF);
    send(ACT_LOOKUP, 16'h0001, 16'h0000);   // cleared table is unsorted
    send(ACT_ADD,    16'h0005, 16'h00FF);
    send(ACT_SORT,   16'h0000, 16'h0000);
    send(ACT_LOOKUP, 16'h0000, 16'h0000);   // search steps below the first entry
    send(ACT_LOOKUP, 16'h0005, 16'h0000);
    drain_results();

    // random sequences until the item budget is spent
    seq_no = 0;
    while (n_sent < ITEM_TARGET) begin
      run_sequence();
      seq_no++;
      if (seq_no == 4 || seq_no == 45) hold_burst();
      if (seq_no % 9 == 0) drain_results();
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("sorted_key_table_search_top_tb: clean");
    else
      $display("sorted_key_table_search_top_tb: errors");
    $finish;
  end

endmodule

@@ sorted_key_table_search_top.f @@
hdl/skts_pkg.sv
hdl/skts_ram.sv
hdl/sorted_key_table_search_top.sv
hdl/skts_assert.sv
test/key_table_checker.sv
test/sorted_key_table_search_top_tb.sv
